// ----- src/lfsc_pkg.sv -----
package lfsc_pkg;

    // Field widths
    localparam int unsigned SPD_W    = 17;
    localparam int unsigned TICK_W   = 32;
    localparam int unsigned DLY_W    = 16;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned DEG_W    = 9;
    localparam int unsigned DIST_W   = 8;
    localparam int unsigned ACT_W    = 2;
    localparam int unsigned SS_W     = 3;
    localparam int unsigned WIDE_W   = SPD_W + 2;
    localparam int unsigned IN_DW    = 40;
    localparam int unsigned OUT_DW   = 56;
    localparam int unsigned APB_AW   = 5;
    localparam int unsigned APB_DW   = 32;

    typedef logic [SPD_W-1:0]         t_spd;
    typedef logic signed [WIDE_W-1:0] t_spd_wide;
    typedef logic [TICK_W-1:0]        t_tick;
    typedef logic [DLY_W-1:0]         t_dly;

    // Speed constants, Q1.16
    localparam t_spd SPD_ONE = 17'd65536;

    // Register reset values
    localparam t_spd RST_BASE_SPEED = 17'd32768;
    localparam t_spd RST_STEP_SIZE  = 17'd7;
    localparam t_spd RST_SPEED_LO   = 17'd13107;
    localparam t_spd RST_SPEED_HI   = 17'd65536;
    localparam t_dly RST_LOST_DLY   = 16'd300;
    localparam t_dly RST_RECOV_DLY  = 16'd50;

    // Register indexes (word address)
    localparam logic [2:0] REG_BASE_SPEED = 3'd0;
    localparam logic [2:0] REG_STEP_SIZE  = 3'd1;
    localparam logic [2:0] REG_MIN_SPEED  = 3'd2;
    localparam logic [2:0] REG_MAX_SPEED  = 3'd3;
    localparam logic [2:0] REG_LOST_DLY   = 3'd4;
    localparam logic [2:0] REG_RECOV_DLY  = 3'd5;

    // Item kinds
    localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STOP   = 2'd2;

    // Search sequence states
    localparam logic [SS_W-1:0] SS_IDLE      = 3'd0;
    localparam logic [SS_W-1:0] SS_ROT_LEFT  = 3'd1;
    localparam logic [SS_W-1:0] SS_ROT_RIGHT = 3'd2;
    localparam logic [SS_W-1:0] SS_ROT_BACK  = 3'd3;
    localparam logic [SS_W-1:0] SS_SEEK      = 3'd4;

    // Drive commands
    localparam logic [CMD_W-1:0] CMD_NONE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ROTATE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DRIVE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd4;

    // Search move parameters
    localparam logic signed [DEG_W-1:0] DEG_P90  = 9'sd90;
    localparam logic signed [DEG_W-1:0] DEG_N90  = -9'sd90;
    localparam logic signed [DEG_W-1:0] DEG_P180 = 9'sd180;
    localparam logic signed [DEG_W-1:0] DEG_N180 = -9'sd180;
    localparam logic [DIST_W-1:0]       SEEK_DIST = 8'd150;

    typedef struct packed {
        logic                      motor_write;
        t_spd                      left_speed;
        t_spd                      right_speed;
        logic [CMD_W-1:0]          drive_cmd;
        logic signed [DEG_W-1:0]   rotate_degrees;
        logic [DIST_W-1:0]         drive_distance;
    } t_result;

endpackage

// ----- src/line_follow_steering_controller.sv -----
// Channel   | Group         | Contents
// ----------+---------------+------------------------------------------------
// input     | s_axis_*      | tuser: action; tdata: sensors, tick, move_done
// output    | m_axis_*      | tdata: motor write, speeds, drive command, move
// config    | APB (psel...) | six registers at byte address 4*i
//
// One item per cycle while the output is not stalled: the item is handled in the cycle it is accepted and
// its result lands in the output register at that edge.
// The result is held in a single result register.
// The input side stays ready while the result register is empty or drained.
// Reset is synchronous and active low; registers except r_out return to their defaults.
module line_follow_steering_controller (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // [0] sense_left, [1] sense_middle, [2] sense_right, [34:3] now_ms,
    // [35] move_done, [39:36] zero
    input  logic [lfsc_pkg::IN_DW-1:0]   s_axis_tdata,
    // [1:0] action
    input  logic [lfsc_pkg::ACT_W-1:0]   s_axis_tuser,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [0] motor_write, [17:1] left_speed, [34:18] right_speed,
    // [37:35] drive_cmd, [46:38] rotate_degrees, [54:47] drive_distance,
    // [55] zero
    output logic [lfsc_pkg::OUT_DW-1:0]  m_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lfsc_pkg::APB_AW-1:0]  paddr,
    input  logic [lfsc_pkg::APB_DW-1:0]  pwdata,
    output logic [lfsc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import lfsc_pkg::*;

    // Configuration registers
    t_spd r_base_speed, r_step_size, r_speed_lo, r_speed_hi;
    t_dly r_lost_dly, r_recov_dly;

    // Controller state
    logic            r_running, n_running;
    t_spd            r_left_vel, n_left_vel;
    t_spd            r_right_vel, n_right_vel;
    t_tick           r_lost_since, n_lost_since;
    logic            r_lost_valid, n_lost_valid;
    t_tick           r_found_since, n_found_since;
    logic            r_found_valid, n_found_valid;
    logic [SS_W-1:0] r_search, n_search;
    logic            r_turn_left, n_turn_left;

    // Result register
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    // Input fields
    logic [ACT_W-1:0] in_action;
    logic             in_sl, in_sm, in_sr, in_done;
    t_tick            in_now;
    logic             in_xfer;

    // Configuration write
    logic             cfg_wr;
    logic [2:0]       cfg_idx;
    t_spd             cfg_spd;

    // Path temporaries
    t_tick            lost_elapsed, found_ref, found_elapsed;
    logic             turn;

    function automatic t_spd clamp_spd(input t_spd_wide v, input t_spd lo, input t_spd hi);
        t_spd_wide x;
        x = v;
        if (x > $signed({2'b00, hi})) x = {2'b00, hi};
        if (x < $signed({2'b00, lo})) x = {2'b00, lo};
        return x[SPD_W-1:0];
    endfunction

    function automatic t_spd_wide toward(input t_spd v, input t_spd base, input t_spd step);
        t_spd_wide x;
        t_spd_wide b;
        t_spd_wide s;
        x = {2'b00, v};
        b = {2'b00, base};
        s = {2'b00, step};
        if (x > b) x = x - s;
        if (x < b) x = x + s;
        return x;
    endfunction

    assign in_action = s_axis_tuser;
    assign in_sl     = s_axis_tdata[0];
    assign in_sm     = s_axis_tdata[1];
    assign in_sr     = s_axis_tdata[2];
    assign in_now    = s_axis_tdata[34:3];
    assign in_done   = s_axis_tdata[35];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.drive_distance, r_out.rotate_degrees,
                            r_out.drive_cmd, r_out.right_speed, r_out.left_speed,
                            r_out.motor_write};

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign cfg_spd = (pwdata[SPD_W-1:0] > SPD_ONE) ? SPD_ONE : pwdata[SPD_W-1:0];

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_BASE_SPEED: prdata = {{(APB_DW-SPD_W){1'b0}}, r_base_speed};
            REG_STEP_SIZE:  prdata = {{(APB_DW-SPD_W){1'b0}}, r_step_size};
            REG_MIN_SPEED:  prdata = {{(APB_DW-SPD_W){1'b0}}, r_speed_lo};
            REG_MAX_SPEED:  prdata = {{(APB_DW-SPD_W){1'b0}}, r_speed_hi};
            REG_LOST_DLY:   prdata = {{(APB_DW-DLY_W){1'b0}}, r_lost_dly};
            REG_RECOV_DLY:  prdata = {{(APB_DW-DLY_W){1'b0}}, r_recov_dly};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_speed <= RST_BASE_SPEED;
            r_step_size  <= RST_STEP_SIZE;
            r_speed_lo   <= RST_SPEED_LO;
            r_speed_hi   <= RST_SPEED_HI;
            r_lost_dly   <= RST_LOST_DLY;
            r_recov_dly  <= RST_RECOV_DLY;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BASE_SPEED: r_base_speed <= cfg_spd;
                REG_STEP_SIZE:  r_step_size  <= cfg_spd;
                REG_MIN_SPEED:  r_speed_lo   <= cfg_spd;
                REG_MAX_SPEED:  r_speed_hi   <= cfg_spd;
                REG_LOST_DLY:   r_lost_dly   <= pwdata[DLY_W-1:0];
                REG_RECOV_DLY:  r_recov_dly  <= pwdata[DLY_W-1:0];
                default: ;
            endcase
        end
    end

    // Steering and search decision for one item
    always_comb begin
        n_running     = r_running;
        n_left_vel    = r_left_vel;
        n_right_vel   = r_right_vel;
        n_lost_since  = r_lost_since;
        n_lost_valid  = r_lost_valid;
        n_found_since = r_found_since;
        n_found_valid = r_found_valid;
        n_search      = r_search;
        n_turn_left   = r_turn_left;
        n_out         = '0;
        turn          = r_turn_left;

        lost_elapsed  = in_now - r_lost_since;
        found_ref     = r_found_valid ? r_found_since : in_now;
        found_elapsed = in_now - found_ref;

        priority if (in_action == ACT_START) begin
            n_left_vel        = r_base_speed;
            n_right_vel       = r_base_speed;
            n_running         = 1'b1;
            n_out.motor_write = 1'b1;
        end else if (in_action == ACT_STOP) begin
            n_left_vel        = '0;
            n_right_vel       = '0;
            n_running         = 1'b0;
            n_out.motor_write = 1'b1;
        end else if (in_action == ACT_UPDATE && r_running) begin
            if (!in_sl && !in_sm && !in_sr) begin
                // Line lost: start timing, then walk the search sequence
                if (!r_lost_valid) begin
                    n_lost_since = in_now;
                    n_lost_valid = 1'b1;
                    n_search     = SS_IDLE;
                end else begin
                    n_found_valid = 1'b0;
                    n_found_since = '0;
                    if (lost_elapsed > {{(TICK_W-DLY_W){1'b0}}, r_lost_dly}) begin
                        unique case (r_search)
                            SS_IDLE: begin
                                n_search             = r_turn_left ? SS_ROT_LEFT : SS_ROT_RIGHT;
                                n_out.rotate_degrees = r_turn_left ? DEG_N90 : DEG_P90;
                                n_out.drive_cmd      = CMD_ROTATE;
                            end
                            SS_ROT_RIGHT: begin
                                if (!in_done) begin
                                    n_out.drive_cmd = CMD_START;
                                end else begin
                                    n_out.rotate_degrees = r_turn_left ? DEG_N90 : DEG_N180;
                                    n_search  = r_turn_left ? SS_ROT_BACK : SS_ROT_LEFT;
                                    n_out.drive_cmd = CMD_ROTATE;
                                end
                            end
                            SS_ROT_LEFT: begin
                                if (!in_done) begin
                                    n_out.drive_cmd = CMD_START;
                                end else begin
                                    n_out.rotate_degrees = r_turn_left ? DEG_P180 : DEG_P90;
                                    n_search  = r_turn_left ? SS_ROT_RIGHT : SS_ROT_BACK;
                                    n_out.drive_cmd = CMD_ROTATE;
                                end
                            end
                            SS_ROT_BACK: begin
                                if (!in_done) begin
                                    n_out.drive_cmd = CMD_START;
                                end else begin
                                    n_out.drive_distance = SEEK_DIST;
                                    n_search             = SS_SEEK;
                                    n_out.drive_cmd      = CMD_DRIVE;
                                end
                            end
                            default: begin
                                // Seek: finish the search once the move is done; an undefined code returns to idle
                                if (in_done || r_search != SS_SEEK) n_search = SS_IDLE;
                                n_out.drive_cmd = CMD_START;
                            end
                        endcase
                    end
                end
            end else begin
                // Line seen: steer toward it
                if (!r_found_valid) begin
                    n_found_since = in_now;
                    n_found_valid = 1'b1;
                end
                priority if (in_sl) begin
                    turn        = 1'b1;
                    n_right_vel = clamp_spd($signed({2'b00, r_right_vel}) +
                                            $signed({2'b00, r_step_size}),
                                            r_speed_lo, r_speed_hi);
                    n_left_vel  = clamp_spd($signed({2'b00, r_left_vel}) -
                                            $signed({2'b00, r_step_size}),
                                            r_speed_lo, r_speed_hi);
                end else if (in_sr) begin
                    turn        = 1'b0;
                    n_left_vel  = clamp_spd($signed({2'b00, r_left_vel}) +
                                            $signed({2'b00, r_step_size}),
                                            r_speed_lo, r_speed_hi);
                    n_right_vel = clamp_spd($signed({2'b00, r_right_vel}) -
                                            $signed({2'b00, r_step_size}),
                                            r_speed_lo, r_speed_hi);
                end else begin
                    n_left_vel  = clamp_spd(toward(r_left_vel, r_base_speed, r_step_size),
                                            r_speed_lo, r_speed_hi);
                    n_right_vel = clamp_spd(toward(r_right_vel, r_base_speed, r_step_size),
                                            r_speed_lo, r_speed_hi);
                end
                if (found_elapsed > {{(TICK_W-DLY_W){1'b0}}, r_recov_dly}) begin
                    n_turn_left       = turn;
                    n_out.drive_cmd   = CMD_CANCEL;
                    n_search          = SS_IDLE;
                    n_lost_valid      = 1'b0;
                    n_lost_since      = '0;
                    n_out.motor_write = 1'b1;
                end
            end
        end else begin
            // Unknown action, or update while stopped: report only
        end

        n_out.left_speed  = n_left_vel;
        n_out.right_speed = n_right_vel;
    end

    // Commit state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running     <= 1'b0;
            r_left_vel    <= '0;
            r_right_vel   <= '0;
            r_lost_since  <= '0;
            r_lost_valid  <= 1'b0;
            r_found_since <= '0;
            r_found_valid <= 1'b0;
            r_search      <= SS_IDLE;
            r_turn_left   <= 1'b0;
        end else if (in_xfer) begin
            r_running     <= n_running;
            r_left_vel    <= n_left_vel;
            r_right_vel   <= n_right_vel;
            r_lost_since  <= n_lost_since;
            r_lost_valid  <= n_lost_valid;
            r_found_since <= n_found_since;
            r_found_valid <= n_found_valid;
            r_search      <= n_search;
            r_turn_left   <= n_turn_left;
        end
    end

    // Hold the result until the output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    a_stopped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_left_vel == '0 && r_right_vel == '0))
        else $error("wheel speeds nonzero while stopped");

    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_search <= SS_SEEK)
        else $error("search sequence left its defined states");

    a_move_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.drive_cmd != CMD_ROTATE |-> r_out.rotate_degrees == '0)
        else $error("rotate angle given without a rotate command");

    a_drive_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.drive_cmd == CMD_DRIVE |-> r_out.drive_distance == SEEK_DIST)
        else $error("drive command without seek distance");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("accepted item produced no result");
`endif

endmodule
